FILE: sv/etc_pkg.sv
// Shared types and constants for the escape-time iteration pipeline.
`default_nettype none
package etc_pkg;

  localparam int FRAC_BITS  = 27;
  localparam int RING_DEPTH = 4;
  localparam int TAG_W      = $clog2(RING_DEPTH);
  localparam int ITER_W     = 16;

  localparam bit THR_ON = (2 * FRAC_BITS + 2) < 64;
  localparam logic [63:0] THRESH = THR_ON ? (64'd1 << ((2 * FRAC_BITS + 2) % 64)) : '1;

  localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
  localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd256;

  typedef struct packed {
    logic                valid;
    logic                done;
    logic                esc;
    logic [TAG_W-1:0]    tag;
    logic [ITER_W-1:0]   iter;
    logic signed [31:0]  re;
    logic signed [31:0]  im;
    logic signed [31:0]  cre;
    logic signed [31:0]  cim;
  } slot_t;

endpackage
`default_nettype wire

FILE: sv/etc_mul_stage.sv
// Pipeline stage 1: squares and cross product of the current z.
`default_nettype none
module etc_mul_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire etc_pkg::slot_t     slot_i,
  output etc_pkg::slot_t          slot_o,
  output logic signed [63:0]      rr_o,
  output logic signed [63:0]      ii_o,
  output logic signed [63:0]      ri_o
);

  etc_pkg::slot_t     slot_r;
  logic signed [63:0] rr_r, ii_r, ri_r;
  logic signed [63:0] rr_nxt, ii_nxt, ri_nxt;

  always_comb begin
    rr_nxt = 64'(slot_i.re) * 64'(slot_i.re);
    ii_nxt = 64'(slot_i.im) * 64'(slot_i.im);
    ri_nxt = 64'(slot_i.re) * 64'(slot_i.im);
  end

  always_ff @(posedge clk) begin
    rr_r   <= rr_nxt;
    ii_r   <= ii_nxt;
    ri_r   <= ri_nxt;
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_i;
    end
  end

  assign slot_o = slot_r;
  assign rr_o   = rr_r;
  assign ii_o   = ii_r;
  assign ri_o   = ri_r;

endmodule
`default_nettype wire

FILE: sv/etc_sat_stage.sv
// Pipeline stage 2: rescale, add c and saturate to form the next z.
`default_nettype none
module etc_sat_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire etc_pkg::slot_t     slot_i,
  input  wire logic signed [63:0] rr_i,
  input  wire logic signed [63:0] ii_i,
  input  wire logic signed [63:0] ri_i,
  output etc_pkg::slot_t          slot_o,
  output logic signed [31:0]      nre_o,
  output logic signed [31:0]      nim_o,
  output logic                    clip_o
);

  etc_pkg::slot_t     slot_r;
  logic signed [31:0] nre_r, nim_r, nre_nxt, nim_nxt;
  logic               clip_r, clip_nxt;
  logic signed [63:0] diff, sh_re, sh_im;
  logic signed [64:0] sum_re, sum_im;

  always_comb begin
    diff   = rr_i - ii_i;
    sh_re  = diff >>> etc_pkg::FRAC_BITS;
    sh_im  = ri_i >>> (etc_pkg::FRAC_BITS - 1);
    sum_re = 65'(sh_re) + 65'(slot_i.cre);
    sum_im = 65'(sh_im) + 65'(slot_i.cim);
    clip_nxt = 1'b0;
    if (sum_re > etc_pkg::SAT_MAX) begin
      nre_nxt  = 32'sh7FFFFFFF;
      clip_nxt = 1'b1;
    end else if (sum_re < etc_pkg::SAT_MIN) begin
      nre_nxt  = 32'sh80000000;
      clip_nxt = 1'b1;
    end else begin
      nre_nxt = sum_re[31:0];
    end
    if (sum_im > etc_pkg::SAT_MAX) begin
      nim_nxt  = 32'sh7FFFFFFF;
      clip_nxt = 1'b1;
    end else if (sum_im < etc_pkg::SAT_MIN) begin
      nim_nxt  = 32'sh80000000;
      clip_nxt = 1'b1;
    end else begin
      nim_nxt = sum_im[31:0];
    end
  end

  always_ff @(posedge clk) begin
    nre_r  <= nre_nxt;
    nim_r  <= nim_nxt;
    clip_r <= clip_nxt;
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_i;
    end
  end

  assign slot_o = slot_r;
  assign nre_o  = nre_r;
  assign nim_o  = nim_r;
  assign clip_o = clip_r;

endmodule
`default_nettype wire

FILE: sv/etc_mag_stage.sv
// Pipeline stages 3 and 4: magnitude squared, escape test and slot update.
`default_nettype none
module etc_mag_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire etc_pkg::slot_t     slot_i,
  input  wire logic signed [31:0] nre_i,
  input  wire logic signed [31:0] nim_i,
  input  wire logic               clip_i,
  input  wire logic [15:0]        max_iter_i,
  output etc_pkg::slot_t          slot_o
);

  etc_pkg::slot_t     slot3_r, slot4_r, slot4_nxt;
  logic signed [31:0] nre3_r, nim3_r;
  logic               clip3_r;
  logic signed [63:0] mr_r, mi_r;
  logic [63:0]        mag;
  logic               hit;
  logic [16:0]        iter_inc;

  always_ff @(posedge clk) begin
    nre3_r  <= nre_i;
    nim3_r  <= nim_i;
    clip3_r <= clip_i;
    mr_r    <= 64'(nre_i) * 64'(nre_i);
    mi_r    <= 64'(nim_i) * 64'(nim_i);
    if (!rst_n) begin
      slot3_r <= '0;
    end else begin
      slot3_r <= slot_i;
    end
  end

  always_comb begin
    mag       = $unsigned(mr_r) + $unsigned(mi_r);
    hit       = clip3_r || (etc_pkg::THR_ON && (mag > etc_pkg::THRESH));
    iter_inc  = 17'(slot3_r.iter) + 17'd1;
    slot4_nxt = slot3_r;
    if (slot3_r.valid && !slot3_r.done) begin
      slot4_nxt.re = nre3_r;
      slot4_nxt.im = nim3_r;
      if (hit) begin
        slot4_nxt.done = 1'b1;
        slot4_nxt.esc  = 1'b1;
      end else begin
        slot4_nxt.iter = iter_inc[15:0];
        if (iter_inc == 17'(max_iter_i)) begin
          slot4_nxt.done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot4_r <= '0;
    end else begin
      slot4_r <= slot4_nxt;
    end
  end

  assign slot_o = slot4_r;

endmodule
`default_nettype wire

FILE: sv/escape_time_iteration.sv
// Top level: four-stage iteration ring with in-order retirement and output register.
// A finished point waits in the ring for older points to retire before its result
// is registered at the output; a point taken while max_iterations is 0 starts done.
// Throughput: the four-stage ring holds up to four points and delivers one iteration
// per cycle while all four are still iterating and none is waiting to retire.
// Reset (synchronous, rst_n low) empties the ring and output, sets max_iterations to 256.
`default_nettype none
module escape_time_iteration (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_start_real,
  input  wire logic signed [31:0] in_start_imag,
  input  wire logic signed [31:0] in_const_real,
  input  wire logic signed [31:0] in_const_imag,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_escaped,
  output logic [15:0]             out_escape_index,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_max_iterations
);

  etc_pkg::slot_t             wb_slot, ring_in, s1_slot, s2_slot;
  logic signed [63:0]         rr, ii, ri;
  logic signed [31:0]         nre, nim;
  logic                       clip;
  logic [15:0]                max_iter_r;
  logic [etc_pkg::TAG_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_esc_r, out_esc_nxt;
  logic [15:0]                out_idx_r, out_idx_nxt;
  logic                       out_free, retire, slot_free, accept;

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    retire    = wb_slot.valid && wb_slot.done && (wb_slot.tag == head_r) && out_free;
    slot_free = !wb_slot.valid || retire;
    accept    = in_valid && slot_free;

    ring_in = wb_slot;
    if (accept) begin
      ring_in.valid = 1'b1;
      ring_in.done  = (max_iter_r == 16'd0);
      ring_in.esc   = 1'b0;
      ring_in.tag   = tail_r;
      ring_in.iter  = '0;
      ring_in.re    = in_start_real;
      ring_in.im    = in_start_imag;
      ring_in.cre   = in_const_real;
      ring_in.cim   = in_const_imag;
    end else if (retire) begin
      ring_in.valid = 1'b0;
    end

    head_nxt = retire ? head_r + 1'b1 : head_r;
    tail_nxt = accept ? tail_r + 1'b1 : tail_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_esc_nxt   = out_esc_r;
    out_idx_nxt   = out_idx_r;
    if (retire) begin
      out_valid_nxt = 1'b1;
      out_esc_nxt   = wb_slot.esc;
      out_idx_nxt   = wb_slot.esc ? wb_slot.iter : 16'd0;
    end
  end

  etc_mul_stage u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .slot_i (ring_in),
    .slot_o (s1_slot),
    .rr_o   (rr),
    .ii_o   (ii),
    .ri_o   (ri)
  );

  etc_sat_stage u_sat (
    .clk    (clk),
    .rst_n  (rst_n),
    .slot_i (s1_slot),
    .rr_i   (rr),
    .ii_i   (ii),
    .ri_i   (ri),
    .slot_o (s2_slot),
    .nre_o  (nre),
    .nim_o  (nim),
    .clip_o (clip)
  );

  etc_mag_stage u_mag (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot_i     (s2_slot),
    .nre_i      (nre),
    .nim_i      (nim),
    .clip_i     (clip),
    .max_iter_i (max_iter_r),
    .slot_o     (wb_slot)
  );

  always_ff @(posedge clk) begin
    out_esc_r <= out_esc_nxt;
    out_idx_r <= out_idx_nxt;
    if (!rst_n) begin
      max_iter_r  <= etc_pkg::MAX_ITER_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_iter_r <= cfg_max_iterations;
      end
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall         = !slot_free;
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_escaped      = out_esc_r;
  assign out_escape_index = out_idx_r;

`ifndef NO_ASSERTIONS
  a_idx_zero_when_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_esc_r |-> out_idx_r == 16'd0)
    else $error("bounded request reported a nonzero index");

  a_idx_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_esc_r |-> out_idx_r < max_iter_r)
    else $error("escape index not below the iteration limit");

  a_retire_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    retire |=> head_r == $past(head_r) + 1'b1)
    else $error("head pointer did not advance on retirement");

  a_no_entry_over_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !wb_slot.valid || (wb_slot.done && wb_slot.tag == head_r))
    else $error("new request overwrote a live slot");
`endif

endmodule
`default_nettype wire
